// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files; permutation_unrank.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge while reset is released.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Checks an implication that must hold in the same cycle.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Checks an implication that must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/punr_pkg.sv =====
package punr_pkg;

    localparam int MAX_ELEMENTS_DEF = 12;
    localparam int COUNT_W          = 4;
    localparam int INDEX_W          = 29;
    localparam int VAL_W            = 4;
    localparam int STATUS_W         = 2;
    localparam int FACT_ENTRIES     = 13;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_ZERO  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic next_digit;
    } div_ctrl_t;

    typedef struct packed {
        logic init;
        logic remove;
    } list_ctrl_t;

    localparam logic [INDEX_W-1:0] FACT_TABLE [FACT_ENTRIES] = '{
        29'd1, 29'd1, 29'd2, 29'd6, 29'd24, 29'd120, 29'd720, 29'd5040,
        29'd40320, 29'd362880, 29'd3628800, 29'd39916800, 29'd479001600
    };

    function automatic logic [INDEX_W-1:0] fact_of(input logic [COUNT_W-1:0] k);
        logic [INDEX_W-1:0] f;
        if (k < COUNT_W'(FACT_ENTRIES)) begin
            f = FACT_TABLE[k];
        end else begin
            f = '0;
        end
        return f;
    endfunction

endpackage

// ===== hw/rtl/punr_divstep.sv =====
module punr_divstep (
    input  logic                          aclk,
    input  punr_pkg::div_ctrl_t           ctrl,
    input  logic [punr_pkg::INDEX_W-1:0]  load_value,
    input  logic [punr_pkg::INDEX_W-1:0]  divisor,
    output logic                          rem_ge,
    output logic [punr_pkg::VAL_W-1:0]    digit
);
    import punr_pkg::*;

    logic [INDEX_W-1:0] rem_reg, rem_next;
    logic [VAL_W-1:0]   digit_reg, digit_next;

    // One compare and subtract per cycle, while ctrl.step is set, builds the quotient digit.
    assign rem_ge = rem_reg >= divisor;
    assign digit  = digit_reg;

    always_comb begin
        rem_next   = rem_reg;
        digit_next = digit_reg;
        if (ctrl.load) begin
            rem_next   = load_value;
            digit_next = '0;
        end else if (ctrl.step) begin
            rem_next   = rem_reg - divisor;
            digit_next = digit_reg + VAL_W'(1);
        end else if (ctrl.next_digit) begin
            digit_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        digit_reg <= digit_next;
    end

endmodule

// ===== hw/rtl/punr_free_list.sv =====
module punr_free_list #(
    parameter int MAX_ELEMENTS = punr_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                        aclk,
    input  punr_pkg::list_ctrl_t        ctrl,
    input  logic [punr_pkg::VAL_W-1:0]  digit,
    output logic [punr_pkg::VAL_W-1:0]  pick
);
    import punr_pkg::*;

    localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    logic [VAL_W-1:0] list_reg  [MAX_ELEMENTS];
    logic [VAL_W-1:0] list_next [MAX_ELEMENTS];

    // The list holds the unused values in ascending order.
    assign pick = list_reg[digit[IDX_W-1:0]];

    always_comb begin
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            list_next[i] = list_reg[i];
        end
        if (ctrl.init) begin
            for (int i = 0; i < MAX_ELEMENTS; i++) begin
                list_next[i] = VAL_W'(i);
            end
        end else if (ctrl.remove) begin
            for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
                if (VAL_W'(i) >= digit) begin
                    list_next[i] = list_reg[i + 1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            list_reg[i] <= list_next[i];
        end
    end

endmodule

// ===== hw/rtl/permutation_unrank.sv =====
// A bad count or index gives its one result in the cycle after the transfer.
// Otherwise each position runs compare/subtract steps until the remainder is below the divisor,
// then waits in the output state until its result is taken; all positions use the shared subtractor.
// One item is in work at a time; s_ready rises after the last result is taken.
// Reset (aresetn low, synchronous) returns the sequencer to idle with no result pending.
module permutation_unrank #(
    parameter int MAX_ELEMENTS = punr_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [punr_pkg::COUNT_W-1:0]   s_element_count,
    input  logic [punr_pkg::INDEX_W-1:0]   s_perm_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [punr_pkg::VAL_W-1:0]     m_position,
    output logic [punr_pkg::VAL_W-1:0]     m_value,
    output logic [punr_pkg::STATUS_W-1:0]  m_status,
    output logic                           m_last
);
    import punr_pkg::*;

    `include "assert_macros.svh"

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] k_reg, k_next;
    logic [VAL_W-1:0]   pos_reg, pos_next;
    logic [VAL_W-1:0]   value_reg, value_next;
    status_t            status_reg, status_next;
    logic               last_reg, last_next;

    div_ctrl_t          div_ctrl;
    list_ctrl_t         list_ctrl;
    logic [INDEX_W-1:0] divisor;
    logic               rem_ge;
    logic [VAL_W-1:0]   digit;
    logic [VAL_W-1:0]   pick;

    assign divisor = fact_of(k_reg - COUNT_W'(1));

    punr_divstep u_divstep (
        .aclk       (aclk),
        .ctrl       (div_ctrl),
        .load_value (s_perm_index),
        .divisor    (divisor),
        .rem_ge     (rem_ge),
        .digit      (digit)
    );

    punr_free_list #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_free_list (
        .aclk  (aclk),
        .ctrl  (list_ctrl),
        .digit (digit),
        .pick  (pick)
    );

    always_comb begin
        state_next  = state_reg;
        k_next      = k_reg;
        pos_next    = pos_reg;
        value_next  = value_reg;
        status_next = status_reg;
        last_next   = last_reg;
        div_ctrl    = '0;
        list_ctrl   = '0;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    pos_next   = '0;
                    value_next = '0;
                    last_next  = 1'b1;
                    if (s_element_count == '0) begin
                        status_next = STATUS_ZERO;
                        state_next  = ST_EMIT;
                    end else if (s_element_count > COUNT_W'(MAX_ELEMENTS) ||
                                 s_perm_index >= fact_of(s_element_count)) begin
                        status_next = STATUS_RANGE;
                        state_next  = ST_EMIT;
                    end else begin
                        status_next    = STATUS_OK;
                        k_next         = s_element_count;
                        div_ctrl.load  = 1'b1;
                        list_ctrl.init = 1'b1;
                        state_next     = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE: begin
                if (rem_ge) begin
                    div_ctrl.step = 1'b1;
                end else begin
                    pos_next            = VAL_W'(k_reg - COUNT_W'(1));
                    value_next          = pick;
                    last_next           = (k_reg == COUNT_W'(1));
                    k_next              = k_reg - COUNT_W'(1);
                    div_ctrl.next_digit = 1'b1;
                    list_ctrl.remove    = 1'b1;
                    state_next          = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = last_reg ? ST_IDLE : ST_DIVIDE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        pos_reg    <= pos_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign m_position = pos_reg;
    assign m_value    = value_reg;
    assign m_status   = status_reg;
    assign m_last     = last_reg;

    `ASSERT_IMPL(a_ready_excl, aclk, aresetn, s_ready, !m_valid, "input ready while a result is pending")
    `ASSERT_IMPL(a_err_last, aclk, aresetn, m_valid && m_status != STATUS_OK, m_last, "error result is not the last of its run")
    `ASSERT_NEXT(a_last_idle, aclk, aresetn, m_valid && m_ready && m_last, s_ready, "not ready after the last transfer of a run")
    `ASSERT_IMPL(a_value_range, aclk, aresetn, m_valid && m_status == STATUS_OK, m_value < VAL_W'(MAX_ELEMENTS) && m_position < VAL_W'(MAX_ELEMENTS), "result field out of range")

endmodule

// ===== dv/permutation_unrank_tb.sv =====
module permutation_unrank_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import punr_pkg::*;

    typedef struct {
        logic [VAL_W-1:0] position;
        logic [VAL_W-1:0] value;
        status_t          status;
        logic             last;
    } placement_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [COUNT_W-1:0]  s_element_count = '0;
    logic [INDEX_W-1:0]  s_perm_index = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [VAL_W-1:0]    m_position;
    logic [VAL_W-1:0]    m_value;
    logic [STATUS_W-1:0] m_status;
    logic                m_last;

    placement_t expected_slots[$];
    placement_t want_slot;
    int         mismatch_count = 0;
    int         items_sent = 0;
    int         results_checked = 0;
    int         rejected_items = 0;
    int         burst_left = 0;
    int         ready_phase = 0;
    logic [15:0] ready_pattern = '1;

    permutation_unrank dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_count (s_element_count),
        .s_perm_index    (s_perm_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_position      (m_position),
        .m_value         (m_value),
        .m_status        (m_status),
        .m_last          (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint unsigned perm_count(input int k);
        longint unsigned f;
        f = 1;
        for (int i = 2; i <= k; i++) begin
            f = f * i;
        end
        return f;
    endfunction

    task automatic predict_placements(input logic [COUNT_W-1:0] n,
                                      input logic [INDEX_W-1:0] idx);
        placement_t      slot;
        longint unsigned rest;
        longint unsigned f;
        longint unsigned digit;
        logic [15:0]     taken;
        int              seen;
        int              pick;
        taken = '0;
        rest = idx;
        if (n == 0) begin
            slot = '{position: '0, value: '0, status: STATUS_ZERO, last: 1'b1};
            expected_slots.push_back(slot);
            rejected_items++;
        end else if (n > MAX_ELEMENTS_DEF || rest >= perm_count(n)) begin
            slot = '{position: '0, value: '0, status: STATUS_RANGE, last: 1'b1};
            expected_slots.push_back(slot);
            rejected_items++;
        end else begin
            for (int k = n; k >= 1; k--) begin
                f = perm_count(k - 1);
                digit = rest / f;
                rest = rest - digit * f;
                seen = 0;
                pick = 0;
                for (int v = 0; v < n; v++) begin
                    if (!taken[v]) begin
                        if (seen == digit) begin
                            pick = v;
                            break;
                        end
                        seen++;
                    end
                end
                taken[pick] = 1'b1;
                slot.position = VAL_W'(k - 1);
                slot.value = VAL_W'(pick);
                slot.status = STATUS_OK;
                slot.last = (k == 1);
                expected_slots.push_back(slot);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic send_item(input logic [COUNT_W-1:0] n, input logic [INDEX_W-1:0] idx);
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            if ($urandom_range(3, 0) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(20, 1)) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_element_count <= n;
        s_perm_index <= idx;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_placements(n, idx);
        items_sent++;
    endtask

    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (expected_slots.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic test_zero_count();
        send_item(4'd0, '0);
        send_item(4'd0, '1);
        send_item(4'd0, 29'd5);
        wait_results_drained();
    endtask

    task automatic test_oversize_count();
        send_item(4'd13, '0);
        send_item(4'd15, '0);
        send_item(4'd14, '1);
        wait_results_drained();
    endtask

    task automatic test_index_range();
        send_item(4'd1, 29'd1);
        send_item(4'd5, 29'd120);
        send_item(4'd12, 29'd479001600);
        send_item(4'd12, '1);
        send_item(4'd3, 29'd6);
        wait_results_drained();
    endtask

    task automatic test_edge_ranks();
        send_item(4'd1, '0);
        send_item(4'd2, 29'd1);
        send_item(4'd3, 29'd5);
        send_item(4'd7, 29'd5039);
        send_item(4'd12, '0);
        send_item(4'd12, 29'd479001599);
        send_item(4'd12, 29'd268435456);
        send_item(4'd11, 29'd39916799);
        wait_results_drained();
    endtask

    task automatic test_random_ranks(input int count);
        logic [COUNT_W-1:0] n;
        logic [INDEX_W-1:0] idx;
        longint unsigned    f;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9, 0) < 8) begin
                n = COUNT_W'($urandom_range(12, 1));
                f = perm_count(n);
                case ($urandom_range(9, 0))
                    0: idx = '0;
                    1: idx = INDEX_W'(f - 1);
                    default: idx = INDEX_W'($urandom_range(32'(f - 1), 0));
                endcase
            end else begin
                n = COUNT_W'($urandom_range(15, 0));
                idx = INDEX_W'($urandom);
            end
            send_item(n, idx);
            if (i == count / 2) begin
                wait_results_drained();
            end
        end
        wait_results_drained();
    endtask

    always @(negedge aclk) begin
        if (ready_phase == 0) begin
            ready_phase = 63;
            case ($urandom_range(3, 0))
                0: ready_pattern = '1;
                1: ready_pattern = 16'($urandom);
                2: ready_pattern = 16'h00ff;
                default: ready_pattern = 16'($urandom | $urandom);
            endcase
        end else begin
            ready_phase--;
        end
        m_ready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_slots.size() == 0) begin
                report_mismatch("unexpected result position", m_position, -1);
            end else begin
                want_slot = expected_slots.pop_front();
                results_checked++;
                if (m_position !== want_slot.position) begin
                    report_mismatch("position", m_position, want_slot.position);
                end
                if (m_value !== want_slot.value) begin
                    report_mismatch("value", m_value, want_slot.value);
                end
                if (m_status !== want_slot.status) begin
                    report_mismatch("status", m_status, want_slot.status);
                end
                if (m_last !== want_slot.last) begin
                    report_mismatch("last", m_last, want_slot.last);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("Timed out with %0d results still outstanding.", expected_slots.size());
        $display("permutation_unrank_tb failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_zero_count();
        test_oversize_count();
        test_index_range();
        test_edge_ranks();
        test_random_ranks(200);

        repeat (100) @(posedge aclk);
        $display("Decoded %0d ranks into %0d checked slots; %0d items were rejected.",
                 items_sent, results_checked, rejected_items);
        $display("Mismatches found: %0d.", mismatch_count);
        if (mismatch_count == 0) begin
            $display("permutation_unrank_tb passed");
        end else begin
            $display("permutation_unrank_tb failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/punr_pkg.sv
hw/rtl/punr_divstep.sv
hw/rtl/punr_free_list.sv
hw/rtl/permutation_unrank.sv
dv/permutation_unrank_tb.sv
